[hdl/grg_pkg.sv]
// shared constants and types for the givens rotation generator
// no dependencies
`default_nettype none

package grg_pkg;

    // default input format, signed q16.16
    localparam int IN_WIDTH_DEF = 32;
    localparam int IN_FRAC_DEF  = 16;

    // output formats
    localparam int TRIG_FRAC    = 30;
    localparam int TRIG_MAG_W   = TRIG_FRAC + 1;
    localparam int TRIG_W       = 32;
    localparam int RADIUS_W     = 34;
    localparam int Z_W          = 32;

    // pipeline stage control handed to each unit
    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

endpackage

`default_nettype wire

[hdl/givens_rotation_generator.sv]
// Givens rotation generator: r, c = a/r, s = b/r and reconstruction z.
// Stages: magnitudes, squares, sum of squares, square root, cosine and sine divides,
// clamp, z divide, output; root and divides are fully pipelined, one bit a stage.
// Throughput is one item per cycle unless the output stalls. Default input is Q16.16.
// A stall at the output holds every stage. rst_n clears all valid bits asynchronously.
// depends on grg_pkg, grg_sqrt_pipe, grg_div_pipe
`default_nettype none

module givens_rotation_generator
    import grg_pkg::*;
#(
    parameter int IN_WIDTH     = IN_WIDTH_DEF,
    parameter int IN_FRAC_BITS = IN_FRAC_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [IN_WIDTH-1:0] a_value,
    input  wire logic signed [IN_WIDTH-1:0] b_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [RADIUS_W-1:0]      radius,
    output logic signed [TRIG_W-1:0]        cosine,
    output logic signed [TRIG_W-1:0]        sine,
    output logic signed [Z_W-1:0]           recon_z,
    output logic                            z_saturated
);

    localparam int MW   = IN_WIDTH;
    localparam int RW   = IN_WIDTH + 1;
    localparam int RXW  = (RW > RADIUS_W) ? RW : RADIUS_W;
    localparam int QZ   = TRIG_FRAC + IN_FRAC_BITS + 1;
    localparam int SH   = TRIG_FRAC - IN_FRAC_BITS;
    localparam int SQ_SIDE_W = 4 + 2 * MW;
    localparam int C_SIDE_W  = 4 + RW;
    localparam int Z_SIDE_W  = 4 + RW + 2 * TRIG_MAG_W;
    localparam logic [TRIG_MAG_W-1:0] ONE_Q30 = TRIG_MAG_W'(1) << TRIG_FRAC;
    localparam logic [QZ:0] Z_POS_LIM = (QZ+1)'(33'h0_7fff_ffff);
    localparam logic [QZ:0] Z_NEG_LIM = (QZ+1)'(33'h0_8000_0000);

    logic       en;
    stage_ctl_t ctl;
    logic       out_valid_reg;

    // global advance: every stage moves unless the output is held
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: magnitudes
    logic          s1_vld_reg;
    logic [MW-1:0] s1_amag_reg, s1_bmag_reg;
    logic          s1_aneg_reg, s1_bneg_reg;

    // stage 2: squares and compare
    logic            s2_vld_reg;
    logic [2*MW-1:0] s2_sqa_reg, s2_sqb_reg;
    logic [MW-1:0]   s2_amag_reg, s2_bmag_reg;
    logic            s2_aneg_reg, s2_bneg_reg, s2_abig_reg, s2_zero_reg;

    // stage 3: sum of squares
    logic            s3_vld_reg;
    logic [2*MW:0]   s3_sum_reg;
    logic [SQ_SIDE_W-1:0] s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_aneg_reg <= a_value[MW-1];
            s1_bneg_reg <= b_value[MW-1];
            s1_amag_reg <= a_value[MW-1] ? MW'(-a_value) : MW'(a_value);
            s1_bmag_reg <= b_value[MW-1] ? MW'(-b_value) : MW'(b_value);

            s2_sqa_reg  <= (2*MW)'(s1_amag_reg) * (2*MW)'(s1_amag_reg);
            s2_sqb_reg  <= (2*MW)'(s1_bmag_reg) * (2*MW)'(s1_bmag_reg);
            s2_amag_reg <= s1_amag_reg;
            s2_bmag_reg <= s1_bmag_reg;
            s2_aneg_reg <= s1_aneg_reg;
            s2_bneg_reg <= s1_bneg_reg;
            s2_abig_reg <= (s1_amag_reg > s1_bmag_reg);
            s2_zero_reg <= (s1_amag_reg == '0) && (s1_bmag_reg == '0);

            s3_sum_reg  <= {1'b0, s2_sqa_reg} + {1'b0, s2_sqb_reg};
            s3_side_reg <= {s2_zero_reg, s2_aneg_reg, s2_bneg_reg, s2_abig_reg,
                            s2_amag_reg, s2_bmag_reg};
        end
    end

    // radius
    stage_ctl_t            sq_ctl;
    logic                  sq_vld;
    logic [RW-1:0]         sq_root;
    logic [SQ_SIDE_W-1:0]  sq_side;

    assign sq_ctl = '{en: en, valid: s3_vld_reg};

    grg_sqrt_pipe #(
        .ROOT_W (RW),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (sq_ctl),
        .rad_in    ({1'b0, s3_sum_reg}),
        .side_in   (s3_side_reg),
        .out_valid (sq_vld),
        .root_out  (sq_root),
        .side_out  (sq_side)
    );

    logic          r_zero, r_aneg, r_bneg, r_abig, r_rneg;
    logic [MW-1:0] r_amag, r_bmag;

    assign {r_zero, r_aneg, r_bneg, r_abig, r_amag, r_bmag} = sq_side;
    assign r_rneg = r_abig ? r_aneg : r_bneg;

    // cosine and sine divides in lockstep
    assign ctl = '{en: en, valid: sq_vld};

    logic                c_vld, s_vld;
    logic [TRIG_MAG_W:0] c_quot, s_quot;
    logic [C_SIDE_W-1:0] c_side;
    logic                s_side;

    grg_div_pipe #(
        .DEN_W  (RW),
        .STEPS  (TRIG_MAG_W),
        .SIDE_W (C_SIDE_W)
    ) u_div_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl),
        .rem_in    ((RW+1)'(r_amag)),
        .den_in    (sq_root),
        .side_in   ({r_zero, r_rneg, r_aneg, r_bneg, sq_root}),
        .out_valid (c_vld),
        .quot_out  (c_quot),
        .side_out  (c_side)
    );

    grg_div_pipe #(
        .DEN_W  (RW),
        .STEPS  (TRIG_MAG_W),
        .SIDE_W (1)
    ) u_div_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl),
        .rem_in    ((RW+1)'(r_bmag)),
        .den_in    (sq_root),
        .side_in   (r_abig),
        .out_valid (s_vld),
        .quot_out  (s_quot),
        .side_out  (s_side)
    );

    // clamp and sign of cosine and sine
    logic                  d_zero, d_rneg, d_aneg, d_bneg;
    logic [RW-1:0]         d_r;
    logic [TRIG_MAG_W-1:0] cmag_next, smag_next;
    logic                  cneg_next, sneg_next;

    assign {d_zero, d_rneg, d_aneg, d_bneg, d_r} = c_side;

    always_comb
    begin
        if (d_zero)
        begin
            cmag_next = ONE_Q30;
            smag_next = '0;
        end
        else
        begin
            cmag_next = (c_quot > (TRIG_MAG_W+1)'(ONE_Q30)) ? ONE_Q30 : c_quot[TRIG_MAG_W-1:0];
            smag_next = (s_quot > (TRIG_MAG_W+1)'(ONE_Q30)) ? ONE_Q30 : s_quot[TRIG_MAG_W-1:0];
        end
        cneg_next = (cmag_next != '0) && (d_aneg != d_rneg);
        sneg_next = (smag_next != '0) && (d_bneg != d_rneg);
    end

    logic                  f_vld_reg;
    logic [TRIG_MAG_W-1:0] f_cmag_reg, f_smag_reg;
    logic                  f_cneg_reg, f_sneg_reg, f_abig_reg, f_rneg_reg;
    logic [RW-1:0]         f_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f_vld_reg <= c_vld && s_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_cmag_reg <= cmag_next;
            f_smag_reg <= smag_next;
            f_cneg_reg <= cneg_next;
            f_sneg_reg <= sneg_next;
            f_abig_reg <= s_side;
            f_rneg_reg <= d_rneg;
            f_r_reg    <= d_r;
        end
    end

    // reciprocal of cosine for z
    stage_ctl_t            z_ctl;
    logic                  z_vld;
    logic [QZ:0]           z_quot;
    logic [Z_SIDE_W-1:0]   z_side;

    assign z_ctl = '{en: en, valid: f_vld_reg};

    grg_div_pipe #(
        .DEN_W  (TRIG_MAG_W),
        .STEPS  (QZ),
        .SIDE_W (Z_SIDE_W)
    ) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (z_ctl),
        .rem_in    ((TRIG_MAG_W+1)'(1)),
        .den_in    (f_cmag_reg),
        .side_in   ({f_abig_reg, f_cneg_reg, f_sneg_reg, f_rneg_reg, f_r_reg,
                     f_cmag_reg, f_smag_reg}),
        .out_valid (z_vld),
        .quot_out  (z_quot),
        .side_out  (z_side)
    );

    logic                  o_abig, o_cneg, o_sneg, o_rneg;
    logic [RW-1:0]         o_r;
    logic [TRIG_MAG_W-1:0] o_cmag, o_smag;

    assign {o_abig, o_cneg, o_sneg, o_rneg, o_r, o_cmag, o_smag} = z_side;

    // z from sine: rescale to the input fraction, ties away from zero
    logic [Z_W-1:0] zs_mag;

    if (SH == 0) begin : g_zs_plain
        assign zs_mag = Z_W'(o_smag);
    end
    else begin : g_zs_round
        logic [TRIG_MAG_W:0] zs_sum;
        assign zs_sum = {1'b0, o_smag} + ((TRIG_MAG_W+1)'(1) << (SH - 1));
        assign zs_mag = Z_W'(zs_sum >> SH);
    end

    // output formatting
    logic [RXW-1:0]      r_ext, r_neg_ext;
    logic [TRIG_W-1:0]   cos_ext, sin_ext;
    logic [Z_W-1:0]      zmag, z_next;
    logic                zneg, sat_next;

    always_comb
    begin
        sat_next = 1'b0;
        if (o_abig)
        begin
            zmag = zs_mag;
            zneg = o_sneg && (zs_mag != '0);
        end
        else if (o_cmag != '0)
        begin
            zneg = o_cneg;
            if (!o_cneg && (z_quot > Z_POS_LIM))
            begin
                zmag     = Z_W'(Z_POS_LIM);
                sat_next = 1'b1;
            end
            else if (o_cneg && (z_quot > Z_NEG_LIM))
            begin
                zmag     = Z_W'(Z_NEG_LIM);
                sat_next = 1'b1;
            end
            else
            begin
                zmag = z_quot[Z_W-1:0];
            end
        end
        else
        begin
            zmag = Z_W'(1) << IN_FRAC_BITS;
            zneg = 1'b0;
        end
        z_next = zneg ? Z_W'(-zmag) : zmag;
    end

    assign r_ext     = RXW'(o_r);
    assign r_neg_ext = o_rneg ? RXW'(-r_ext) : r_ext;
    assign cos_ext   = o_cneg ? TRIG_W'(-{1'b0, o_cmag}) : TRIG_W'(o_cmag);
    assign sin_ext   = o_sneg ? TRIG_W'(-{1'b0, o_smag}) : TRIG_W'(o_smag);

    logic [RADIUS_W-1:0] radius_reg;
    logic [TRIG_W-1:0]   cosine_reg, sine_reg;
    logic [Z_W-1:0]      recon_z_reg;
    logic                z_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= z_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            radius_reg  <= r_neg_ext[RADIUS_W-1:0];
            cosine_reg  <= cos_ext;
            sine_reg    <= sin_ext;
            recon_z_reg <= z_next;
            z_sat_reg   <= sat_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign radius      = radius_reg;
    assign cosine      = cosine_reg;
    assign sine        = sine_reg;
    assign recon_z     = recon_z_reg;
    assign z_saturated = z_sat_reg;

`ifndef NO_ASSERTIONS
    // a clipped z sits on one of the range ends
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && z_saturated |-> (recon_z == 32'sh7fff_ffff) || (recon_z == 32'sh8000_0000))
        else $error("saturated z not at a range limit");

    // cosine and sine stay within plus or minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cosine <= 32'sh4000_0000) && (cosine >= -32'sh4000_0000)
                   && (sine <= 32'sh4000_0000) && (sine >= -32'sh4000_0000))
        else $error("cosine or sine out of unit range");

    // a held result item stays in place until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(recon_z) && $stable(radius))
        else $error("pipeline moved while output held");
`endif

endmodule

`default_nettype wire

[hdl/grg_sqrt_pipe.sv]
// pipelined rounded integer square root, one result bit per stage
// depends on grg_pkg
`default_nettype none

module grg_sqrt_pipe
    import grg_pkg::*;
#(
    parameter int ROOT_W = IN_WIDTH_DEF + 1,
    parameter int SIDE_W = 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire stage_ctl_t            ctl_in,
    input  wire logic [2*ROOT_W-1:0]   rad_in,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic                       out_valid,
    output logic [ROOT_W-1:0]          root_out,
    output logic [SIDE_W-1:0]          side_out
);

    localparam int NW    = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;

    logic [NW-1:0]     rad_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];

    logic [ROOT_W-1:0] fin_root_reg;
    logic [SIDE_W-1:0] fin_side_reg;
    logic              fin_vld_reg;
    logic              round_up;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [NW-1:0]     rad_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [REM_W-1:0]  rem_cur;
        logic [SIDE_W-1:0] side_cur;
        logic              vld_cur;
        logic [SH_W-1:0]   rem_sh;
        logic [SH_W-1:0]   trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;

        if (k == 0) begin : g_first
            assign rad_cur  = rad_in;
            assign root_cur = '0;
            assign rem_cur  = '0;
            assign side_cur = side_in;
            assign vld_cur  = ctl_in.valid;
        end
        else begin : g_next
            assign rad_cur  = rad_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        // bring down the next two radicand bits and try the next root bit
        assign rem_sh   = {rem_cur, rad_cur[NW-1 -: 2]};
        assign trial    = {2'b00, root_cur, 2'b01};
        assign ge       = (rem_sh >= trial);
        assign rem_next = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ctl_in.en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl_in.en)
            begin
                rad_reg[k]  <= {rad_cur[NW-3:0], 2'b00};
                root_reg[k] <= {root_cur[ROOT_W-2:0], ge};
                rem_reg[k]  <= rem_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    // round to nearest: remainder above the floor root means up
    assign round_up = (rem_reg[ROOT_W-1] > REM_W'(root_reg[ROOT_W-1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else if (ctl_in.en)
        begin
            fin_vld_reg <= vld_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.en)
        begin
            fin_root_reg <= root_reg[ROOT_W-1] + ROOT_W'(round_up);
            fin_side_reg <= side_reg[ROOT_W-1];
        end
    end

    assign out_valid = fin_vld_reg;
    assign root_out  = fin_root_reg;
    assign side_out  = fin_side_reg;

endmodule

`default_nettype wire

[hdl/grg_div_pipe.sv]
// pipelined restoring divider with round-to-nearest, one quotient bit per stage
// depends on grg_pkg
`default_nettype none

module grg_div_pipe
    import grg_pkg::*;
#(
    parameter int DEN_W  = IN_WIDTH_DEF + 1,
    parameter int STEPS  = TRIG_MAG_W,
    parameter int SIDE_W = 1
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire stage_ctl_t          ctl_in,
    input  wire logic [DEN_W:0]      rem_in,
    input  wire logic [DEN_W-1:0]    den_in,
    input  wire logic [SIDE_W-1:0]   side_in,
    output logic                     out_valid,
    output logic [STEPS:0]           quot_out,
    output logic [SIDE_W-1:0]        side_out
);

    logic [DEN_W-1:0]  rem_reg  [STEPS];
    logic [DEN_W-1:0]  den_reg  [STEPS];
    logic [STEPS-1:0]  quot_reg [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic              vld_reg  [STEPS];

    logic [STEPS:0]    fin_quot_reg;
    logic [SIDE_W-1:0] fin_side_reg;
    logic              fin_vld_reg;
    logic              round_up;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [DEN_W:0]    rem_cur;
        logic [DEN_W-1:0]  den_cur;
        logic [STEPS-1:0]  quot_cur;
        logic [SIDE_W-1:0] side_cur;
        logic              vld_cur;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;

        if (k == 0) begin : g_first
            assign rem_cur  = rem_in;
            assign den_cur  = den_in;
            assign quot_cur = '0;
            assign side_cur = side_in;
            assign vld_cur  = ctl_in.valid;
        end
        else begin : g_next
            assign rem_cur  = {rem_reg[k-1], 1'b0};
            assign den_cur  = den_reg[k-1];
            assign quot_cur = quot_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        // trial subtract of the divisor
        assign ge       = (rem_cur >= {1'b0, den_cur});
        assign rem_next = ge ? DEN_W'(rem_cur - {1'b0, den_cur}) : rem_cur[DEN_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (ctl_in.en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl_in.en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_cur;
                quot_reg[k] <= {quot_cur[STEPS-2:0], ge};
                side_reg[k] <= side_cur;
            end
        end
    end

    // round half up on the final remainder
    assign round_up = ({rem_reg[STEPS-1], 1'b0} >= {1'b0, den_reg[STEPS-1]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else if (ctl_in.en)
        begin
            fin_vld_reg <= vld_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.en)
        begin
            fin_quot_reg <= {1'b0, quot_reg[STEPS-1]} + (STEPS+1)'(round_up);
            fin_side_reg <= side_reg[STEPS-1];
        end
    end

    assign out_valid = fin_vld_reg;
    assign quot_out  = fin_quot_reg;
    assign side_out  = fin_side_reg;

endmodule

`default_nettype wire

[tb/givens_rotation_checker.sv]
// checker for the givens rotation generator: watches both channels, predicts each result
// with wide exact arithmetic and compares all fields of each result together
// depends on grg_pkg
`default_nettype none

module givens_rotation_checker
    import grg_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_ready,
    input  wire logic signed [31:0]        a_value,
    input  wire logic signed [31:0]        b_value,
    input  wire logic                      out_valid,
    input  wire logic                      out_ready,
    input  wire logic signed [RADIUS_W-1:0] radius,
    input  wire logic signed [TRIG_W-1:0]  cosine,
    input  wire logic signed [TRIG_W-1:0]  sine,
    input  wire logic signed [Z_W-1:0]     recon_z,
    input  wire logic                      z_saturated,
    output int                             fail_count,
    output int                             pending_count
);

    localparam int FRAC = 16;

    typedef struct packed {
        logic [RADIUS_W-1:0] r;
        logic [TRIG_W-1:0]   c;
        logic [TRIG_W-1:0]   s;
        logic [Z_W-1:0]      z;
        logic                sat;
    } rotation_t;

    rotation_t rotation_q[$];

    // round(num / d), ties up
    function automatic logic [127:0] div_nearest(input logic [127:0] num,
                                                 input logic [127:0] d);
        logic [127:0] q;
        logic [127:0] rem;
        q   = num / d;
        rem = num % d;
        if (rem >= d - rem)
            q = q + 1;
        return q;
    endfunction

    // rounded root of a squared plus b squared
    function automatic logic [63:0] root_nearest(input logic [127:0] n);
        logic [63:0]  f;
        logic [63:0]  cand;
        f = 0;
        for (int bit_i = 63; bit_i >= 0; bit_i--)
        begin
            cand = f | (64'd1 << bit_i);
            if ({64'd0, cand} * {64'd0, cand} <= n)
                f = cand;
        end
        if (n > {64'd0, f} * {64'd0, f} + {64'd0, f})
            f = f + 1;
        return f;
    endfunction

    function automatic rotation_t predict_rotation(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        rotation_t    res;
        logic [63:0]  amag;
        logic [63:0]  bmag;
        logic [63:0]  rmag;
        logic [63:0]  cmag;
        logic [63:0]  smag;
        logic [63:0]  zmag;
        logic         aneg;
        logic         bneg;
        logic         rneg;
        logic         cneg;
        logic         sneg;
        logic         zneg;
        logic         sat;
        logic         a_big;
        aneg = a[31];
        bneg = b[31];
        amag = aneg ? 64'(-{{32{a[31]}}, a}) : 64'(a);
        bmag = bneg ? 64'(-{{32{b[31]}}, b}) : 64'(b);
        a_big = amag > bmag;
        rmag = 0;
        rneg = 0;
        cneg = 0;
        sneg = 0;
        zneg = 0;
        sat  = 0;
        if (amag == 0 && bmag == 0)
        begin
            cmag = 64'd1 << 30;
            smag = 0;
        end
        else
        begin
            rmag = root_nearest({64'd0, amag} * amag + {64'd0, bmag} * bmag);
            rneg = a_big ? aneg : bneg;
            cmag = 64'(div_nearest({64'd0, amag} << 30, {64'd0, rmag}));
            smag = 64'(div_nearest({64'd0, bmag} << 30, {64'd0, rmag}));
            if (cmag > (64'd1 << 30)) cmag = 64'd1 << 30;
            if (smag > (64'd1 << 30)) smag = 64'd1 << 30;
            cneg = (cmag != 0) && (aneg != rneg);
            sneg = (smag != 0) && (bneg != rneg);
        end
        // reconstruction value
        if (a_big)
        begin
            zmag = (smag + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
            zneg = sneg && zmag != 0;
        end
        else if (cmag != 0)
        begin
            zmag = 64'(div_nearest(128'd1 << (30 + FRAC), {64'd0, cmag}));
            zneg = cneg;
            if (!zneg && zmag > 64'h7FFF_FFFF)
            begin
                zmag = 64'h7FFF_FFFF;
                sat  = 1;
            end
            if (zneg && zmag > 64'h8000_0000)
            begin
                zmag = 64'h8000_0000;
                sat  = 1;
            end
        end
        else
            zmag = 64'd1 << FRAC;
        res.r   = RADIUS_W'(rneg ? -rmag : rmag);
        res.c   = TRIG_W'(cneg ? -cmag : cmag);
        res.s   = TRIG_W'(sneg ? -smag : smag);
        res.z   = Z_W'(zneg ? -zmag : zmag);
        res.sat = sat;
        return res;
    endfunction

    assign pending_count = rotation_q.size();

    // predict on input items, compare on result items
    always @(posedge clk or negedge rst_n)
    begin
        rotation_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                rotation_q.push_back(predict_rotation(a_value, b_value));
            if (out_valid && out_ready)
            begin
                if (rotation_q.size() == 0)
                begin
                    $display("%0t: result item with none expected r=%h", $time, radius);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = rotation_q.pop_front();
                    if (want != {radius, cosine, sine, recon_z, z_saturated})
                    begin
                        $display("%0t: mismatch expected r=%h c=%h s=%h z=%h sat=%b", $time,
                                 want.r, want.c, want.s, want.z, want.sat);
                        $display("%0t:          actual   r=%h c=%h s=%h z=%h sat=%b", $time,
                                 radius, cosine, sine, recon_z, z_saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[tb/tb_givens_rotation_generator.sv]
// testbench top for the givens rotation generator: directed and random pairs with
// random idling on both channels; checking is done by givens_rotation_checker
// depends on grg_pkg, givens_rotation_generator, givens_rotation_checker
`default_nettype none

module tb_givens_rotation_generator;
    import grg_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_ITEMS  = 200;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 60000;

    logic                      clk = 0;
    logic                      rst_n = 0;
    logic                      in_valid = 0;
    logic                      in_ready;
    logic signed [31:0]        a_value = 0;
    logic signed [31:0]        b_value = 0;
    logic                      out_valid;
    logic                      out_ready = 0;
    logic signed [RADIUS_W-1:0] radius;
    logic signed [TRIG_W-1:0]  cosine;
    logic signed [TRIG_W-1:0]  sine;
    logic signed [Z_W-1:0]     recon_z;
    logic                      z_saturated;
    int                        fail_count;
    int                        pending_count;
    int                        cycle_count = 0;
    bit                        quiet = 0;

    always #1 clk = ~clk;

    givens_rotation_generator dut (.*);

    givens_rotation_checker chk (.*);

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** givens_rotation_generator: FAILED **");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        int stall;
        if (rst_n)
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 3);
                out_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
        end
    end

    // random operand with extremes and small values weighted in
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 3) - 2;
            3: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // send one item, with an optional burst of idle before it
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1;
        a_value  <= a;
        b_value  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] x;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: zeros, extremes, ties, tiny values, cosine rounding to zero
        send_pair(0, 0);
        send_pair(32'h0001_0000, 0);
        send_pair(0, 32'h0001_0000);
        send_pair(32'hFFFF_0000, 0);
        send_pair(0, 32'hFFFF_0000);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'h0003_0000, 32'hFFFC_0000);
        send_pair(32'hFFFD_0000, 32'h0004_0000);
        send_pair(5, 5);
        send_pair(-5, 5);
        send_pair(1, 32'h7FFF_FFFF);
        send_pair(-1, 32'h8000_0000);
        send_pair(32'h0000_0100, 32'h7000_0000);
        send_pair(32'hFFFF_FF00, 32'h9000_0000);
        send_pair(32'h7FFF_FFFF, 1);
        send_pair(32'h8000_0000, -1);
        send_pair(1, 0);
        send_pair(-1, -1);
        // pause until every expected result is back
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        // random part
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1;
            x = pick_operand();
            send_pair(x, ($urandom_range(0, 9) == 0) ? x : pick_operand());
        end
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** givens_rotation_generator: PASSED **");
        else
            $display("** givens_rotation_generator: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
